FILE: src/fixed_point_alu_unit_assert.svh
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define FIXED_POINT_ALU_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FPA_ASSERT_IMPL(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("fixed_point_alu_unit: assertion failed");
`define FPA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("fixed_point_alu_unit: assertion failed");
`else
`define FPA_ASSERT_IMPL(label, prop)
`define FPA_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: src/fpa_pkg.sv
package fpa_pkg;

    localparam logic [3:0] ACT_ADD      = 4'd0;
    localparam logic [3:0] ACT_SUB      = 4'd1;
    localparam logic [3:0] ACT_MUL      = 4'd2;
    localparam logic [3:0] ACT_DIV      = 4'd3;
    localparam logic [3:0] ACT_LT       = 4'd4;
    localparam logic [3:0] ACT_GT       = 4'd5;
    localparam logic [3:0] ACT_LE       = 4'd6;
    localparam logic [3:0] ACT_GE       = 4'd7;
    localparam logic [3:0] ACT_EQ       = 4'd8;
    localparam logic [3:0] ACT_NE       = 4'd9;
    localparam logic [3:0] ACT_MIN      = 4'd10;
    localparam logic [3:0] ACT_MAX      = 4'd11;
    localparam logic [3:0] ACT_INC      = 4'd12;
    localparam logic [3:0] ACT_DEC      = 4'd13;
    localparam logic [3:0] ACT_FROM_INT = 4'd14;
    localparam logic [3:0] ACT_TO_INT   = 4'd15;

endpackage

FILE: src/fixed_point_alu_unit.sv
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits. One beat in
// carries an action and two raw operands; one beat out carries the wrapped
// result and the compare and divide-by-zero flags. The unit takes a new beat
// every cycle while the output is not stalled; every action has the same latency.
// The latency is set by the divider, which spends one pipeline stage per
// quotient bit on a 32 + FRAC_BITS bit dividend. Stages advance
// independently, so bubbles close up while the output is stalled.

`include "fixed_point_alu_unit_assert.svh"

module fixed_point_alu_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // action[3:0], operand_a[35:4], operand_b[67:36]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // result[31:0], compare_true[32], divide_by_zero[33]
);
    import fpa_pkg::*;

    localparam int MW = 32 + FRAC_BITS;
    localparam int NS = MW + 3;

    typedef struct packed {
        logic [3:0]         act;
        logic [31:0]        a;
        logic [31:0]        b;
        logic [31:0]        res;
        logic               cmp;
        logic               dz;
        logic               neg;
        logic signed [63:0] prod;
        logic [31:0]        dvs;
        logic [32:0]        rem;
        logic [MW-1:0]      quo;
    } t_stage;

    t_stage          r_pipe [NS];
    t_stage          n_pipe [NS];
    logic [NS-1:0]   r_v;
    logic [NS-1:0]   n_v;
    logic [NS:0]     en;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        en[NS] = i_m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign n_v = {r_v[NS-2:0], i_s_tvalid};

    always_comb begin
        t_stage             p;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic signed [63:0] prod_t;
        logic signed [63:0] prod_sh;
        logic [31:0]        amag;
        logic [31:0]        bmag;
        logic [32:0]        trial;
        logic [32:0]        diff;
        logic [31:0]        qlo;
        p       = '0;
        sa      = '0;
        sb      = '0;
        prod_t  = '0;
        prod_sh = '0;
        amag    = '0;
        bmag    = '0;
        trial   = '0;
        diff    = '0;
        qlo     = '0;
        for (int k = 0; k < NS; k++) begin
            p = r_pipe[(k > 0) ? k - 1 : 0];
            n_pipe[k] = p;
            if (k == 0) begin
                n_pipe[k].act = i_s_tdata[3:0];
                n_pipe[k].a   = i_s_tdata[35:4];
                n_pipe[k].b   = i_s_tdata[67:36];
            end else if (k == 1) begin
                sa = $signed(p.a);
                sb = $signed(p.b);
                prod_t = sa * sb;
                n_pipe[k].prod = prod_t;
                n_pipe[k].res  = '0;
                n_pipe[k].cmp  = 1'b0;
                amag = p.a[31] ? (~p.a + 32'd1) : p.a;
                bmag = p.b[31] ? (~p.b + 32'd1) : p.b;
                n_pipe[k].quo = MW'(amag) << FRAC_BITS;
                n_pipe[k].dvs = bmag;
                n_pipe[k].rem = '0;
                n_pipe[k].neg = p.a[31] ^ p.b[31];
                n_pipe[k].dz  = (p.act == ACT_DIV) && (p.b == 32'd0);
                unique case (p.act)
                    ACT_ADD:      n_pipe[k].res = p.a + p.b;
                    ACT_SUB:      n_pipe[k].res = p.a - p.b;
                    ACT_MUL:      n_pipe[k].res = '0;
                    ACT_DIV:      n_pipe[k].res = '0;
                    ACT_LT:       n_pipe[k].cmp = sa < sb;
                    ACT_GT:       n_pipe[k].cmp = sa > sb;
                    ACT_LE:       n_pipe[k].cmp = sa <= sb;
                    ACT_GE:       n_pipe[k].cmp = sa >= sb;
                    ACT_EQ:       n_pipe[k].cmp = sa == sb;
                    ACT_NE:       n_pipe[k].cmp = sa != sb;
                    ACT_MIN:      n_pipe[k].res = (sa < sb) ? p.a : p.b;
                    ACT_MAX:      n_pipe[k].res = (sa > sb) ? p.a : p.b;
                    ACT_INC:      n_pipe[k].res = p.a + 32'd1;
                    ACT_DEC:      n_pipe[k].res = p.a - 32'd1;
                    ACT_FROM_INT: n_pipe[k].res = p.a << FRAC_BITS;
                    ACT_TO_INT:   n_pipe[k].res = 32'(sa >>> FRAC_BITS);
                    default:      n_pipe[k].res = '0;
                endcase
            end else if (k < NS - 1) begin
                // one restoring division step on magnitudes
                trial = {p.rem[31:0], p.quo[MW-1]};
                diff  = trial - {1'b0, p.dvs};
                if (!diff[32]) begin
                    n_pipe[k].rem = diff;
                    n_pipe[k].quo = {p.quo[MW-2:0], 1'b1};
                end else begin
                    n_pipe[k].rem = trial;
                    n_pipe[k].quo = {p.quo[MW-2:0], 1'b0};
                end
            end else begin
                prod_sh = p.prod >>> FRAC_BITS;
                qlo = p.quo[31:0];
                if (p.act == ACT_MUL) begin
                    n_pipe[k].res = prod_sh[31:0];
                end else if (p.act == ACT_DIV) begin
                    n_pipe[k].res = p.dz ? 32'd0 : (p.neg ? (~qlo + 32'd1) : qlo);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_v[NS-1];
    assign o_m_tdata  = {6'b0, r_pipe[NS-1].dz, r_pipe[NS-1].cmp, r_pipe[NS-1].res};

    `FPA_ASSERT_IMPL(a_dz_zero, (r_v[NS-1] && r_pipe[NS-1].dz) |-> (r_pipe[NS-1].res == 32'd0))
    `FPA_ASSERT_IMPL(a_cmp_only, (r_v[NS-1] && r_pipe[NS-1].cmp) |->
        (r_pipe[NS-1].act >= ACT_LT && r_pipe[NS-1].act <= ACT_NE))
    `FPA_ASSERT_NEXT(a_out_hold, (r_v[NS-1] && !i_m_tready), r_v[NS-1])

endmodule
